// ===== sv/servo_pulse_sequencer_macros.svh =====
// Assertion macros for the servo pulse sequencer checker.
// Every macro samples on the rising edge of clk and is held off while rst_n is low.
`ifndef SERVO_PULSE_SEQUENCER_MACROS_SVH
`define SERVO_PULSE_SEQUENCER_MACROS_SVH

// Check a property on every clock edge outside reset
`define SPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by a property in the next cycle
`define SPS_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== sv/sps_pkg.sv =====
// Shared types, constants and helper functions for the servo pulse sequencer.
// Used by the divider, the top level and the checker.
package sps_pkg;

    // Channel count and derived address width
    localparam int CHANNELS = 12;
    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths
    localparam int FUNC_W  = 2;
    localparam int CH_W    = 4;
    localparam int VAL_W   = 16;
    localparam int US_W    = 12;
    localparam int PIN_W   = 12;
    localparam int ANG_W   = 8;
    localparam int STAT_W  = 2;
    localparam int TRIM_W  = 8;
    localparam int LIM_W   = 14;
    localparam int SPAN_W  = 15;
    localparam int SLOT_W  = 5;
    localparam int CNT_W   = 16;
    localparam int SUM_W   = 17;
    localparam int WV_W    = 31;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;
    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 32;

    // Divider geometry
    localparam int DIV_NUM_W = 30;
    localparam int DIV_DEN_W = 15;
    localparam int DIV_BITS  = 2;

    // Item kinds
    typedef enum logic [FUNC_W-1:0] {
        FN_TICK,
        FN_ATTACH,
        FN_DETACH,
        FN_WRITE
    } func_t;

    // Result status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] REG_SERVO_COUNT   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_REFRESH_TICKS = 3'd1;
    localparam logic [CFG_AW-1:0] REG_MIN_PULSE     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_PULSE     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DEFAULT_PULSE = 3'd4;

    // Reset values
    localparam logic [CH_W-1:0]  RST_SERVO_COUNT = 4'd0;
    localparam logic [CNT_W-1:0] RST_REFRESH     = 16'd20000;
    localparam logic [US_W-1:0]  RST_MIN_PULSE   = 12'd544;
    localparam logic [US_W-1:0]  RST_MAX_PULSE   = 12'd2400;
    localparam logic [US_W-1:0]  RST_DEFAULT     = 12'd1500;

    // Sequencer constants
    localparam logic [SLOT_W-1:0]     SLOT_GAP    = '1;
    localparam logic [CNT_W-1:0]      OVERRUN_GAP = 16'd4;
    localparam logic signed [8:0]     ANGLE_SPAN  = 9'sd180;
    localparam logic [ANG_W-1:0]      ANGLE_MAX   = 8'd255;
    localparam logic [US_W-1:0]       US_MAX      = 12'd4095;

    // One channel table entry
    typedef struct packed {
        logic [US_W-1:0]          width;
        logic signed [TRIM_W-1:0] low_trim;
        logic signed [TRIM_W-1:0] high_trim;
    } chan_entry_t;

    localparam int ENTRY_W = $bits(chan_entry_t);
    localparam chan_entry_t ENTRY_RESET = '{RST_DEFAULT, 8'sd0, 8'sd0};

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TICK,
        ST_LOAD,
        ST_CH_RD,
        ST_CH,
        ST_WR_MUL,
        ST_WR_DIV,
        ST_WR_CLAMP,
        ST_RB_MUL,
        ST_RB_DIV,
        ST_OUT
    } state_t;

    // Trim in 4 us units: (nominal - wanted) / 4, toward zero, saturated to 8 bits
    function automatic logic signed [TRIM_W-1:0] sat_trim(input logic [US_W-1:0] nom,
                                                          input logic [US_W-1:0] want);
        logic signed [US_W:0] diff;
        logic signed [US_W:0] quo;
        diff = $signed({1'b0, nom}) - $signed({1'b0, want});
        if (diff < 0)
            quo = (diff + 13'sd3) >>> 2;
        else
            quo = diff >>> 2;
        if (quo > 13'sd127)
            return 8'sd127;
        else if (quo < -13'sd128)
            return -8'sd128;
        else
            return quo[TRIM_W-1:0];
    endfunction

    // Trimmed limit: nominal minus four times the trim
    function automatic logic signed [LIM_W-1:0] trim_limit(input logic [US_W-1:0] nom,
                                                           input logic signed [TRIM_W-1:0] trim);
        logic signed [LIM_W-1:0] trim_x;
        trim_x = $signed({{(LIM_W-TRIM_W){trim[TRIM_W-1]}}, trim});
        return $signed({{(LIM_W-US_W){1'b0}}, nom}) - (trim_x <<< 2);
    endfunction

endpackage

// ===== sv/servo_pulse_sequencer.sv =====
// Multiplexed RC servo pulse generator: one microsecond tick steps a single
// interval timer through channels 0 .. servo_count-1, raising each active
// channel's pin for its stored width, then idles out the rest of the refresh
// frame (or 4 ticks when the frame is overrun). Channel widths and trims live
// in a 12-entry synchronous RAM; reset-valued entries are covered by valid bits,
// so the block takes items straight out of reset. Items are taken one at a
// time: s_tready stays low until the result of the last item is handed to
// the output register. The two-bit-per-cycle divider forms the read-back
// angle and scales angles to microseconds, and each channel lookup waits on
// the registered RAM read. Depends on sps_pkg, sps_ram and sps_div.
module servo_pulse_sequencer
    import sps_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input items
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // channel, value, min_us, max_us, zero pad
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    // Result items
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // pin_levels, width_us, angle_deg
    output logic [STAT_W-1:0]     m_tuser,   // status
    // Configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_AW-1:0]     cfg_addr,
    input  logic [CFG_DW-1:0]     cfg_wdata
);

    // Control state
    state_t                   state_reg, state_next;
    logic [CH_W-1:0]          servo_count_reg, servo_count_next;
    logic [CNT_W-1:0]         refresh_reg, refresh_next;
    logic [US_W-1:0]          min_pulse_reg, min_pulse_next;
    logic [US_W-1:0]          max_pulse_reg, max_pulse_next;
    logic [US_W-1:0]          default_reg, default_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic [CNT_W-1:0]         countdown_reg, countdown_next;
    logic [SUM_W-1:0]         frame_sum_reg, frame_sum_next;
    logic [CHANNELS-1:0]      active_reg, active_next;
    logic [CHANNELS-1:0]      entry_vld_reg, entry_vld_next;
    logic [CHANNELS-1:0]      pins_reg, pins_next;
    logic                     running_reg, running_next;
    logic                     div_go_reg, div_go_next;
    logic                     m_tvalid_reg, m_tvalid_next;

    // Item and working payload
    func_t                    func_reg, func_next;
    logic [CH_W-1:0]          ch_reg, ch_next;
    logic signed [VAL_W-1:0]  v_reg, v_next;
    logic [US_W-1:0]          min_us_reg, min_us_next;
    logic [US_W-1:0]          max_us_reg, max_us_next;
    chan_entry_t              cur_reg, cur_next;
    logic                     rd_vld_reg, rd_vld_next;
    logic signed [DIV_NUM_W-1:0] mul_reg, mul_next;
    logic signed [DIV_DEN_W-1:0] den_reg, den_next;
    logic signed [WV_W-1:0]   wval_reg, wval_next;
    logic [ANG_W-1:0]         res_angle_reg, res_angle_next;
    logic [STAT_W-1:0]        res_status_reg, res_status_next;
    logic [PIN_W-1:0]         out_pins_reg, out_pins_next;
    logic [US_W-1:0]          out_width_reg, out_width_next;
    logic [ANG_W-1:0]         out_angle_reg, out_angle_next;
    logic [STAT_W-1:0]        out_status_reg, out_status_next;

    // RAM port
    logic                     ram_we;
    logic [CH_AW-1:0]         ram_waddr;
    chan_entry_t              ram_wdata;
    logic                     ram_re;
    logic [CH_AW-1:0]         ram_raddr;
    logic [ENTRY_W-1:0]       ram_rdata;

    // Divider port
    logic                        div_done;
    logic signed [DIV_NUM_W-1:0] div_quo;

    // Decoded helpers
    chan_entry_t              ent;
    logic [CH_W-1:0]          used;
    logic [CHANNELS-1:0]      ch_mask;
    logic [CHANNELS-1:0]      slot_mask;
    logic                     ch_valid;
    logic                     slot_in_use;
    logic [SLOT_W-1:0]        slot_inc;
    logic                     expire_now;
    logic                     write_angle;
    logic signed [LIM_W-1:0]  lo_s;
    logic signed [LIM_W-1:0]  hi_s;
    logic signed [SPAN_W-1:0] span;
    logic signed [VAL_W+SPAN_W-1:0] wr_prod;
    logic signed [SPAN_W-1:0] rb_off;
    logic signed [SPAN_W+8:0] rb_prod;
    logic signed [WV_W-1:0]   lo_x;
    logic signed [WV_W-1:0]   hi_x;
    logic signed [WV_W-1:0]   w_lim;
    logic [US_W-1:0]          w_sat;
    logic                     out_free;

    sps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CHANNELS)
    ) u_chan_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    sps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_go_reg),
        .num   (mul_reg),
        .den   (den_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    // Entry read back, reset value where never written
    assign ent = rd_vld_reg ? chan_entry_t'(ram_rdata) : ENTRY_RESET;

    // Channel and slot decode
    assign used = (servo_count_reg > CH_W'(CHANNELS)) ? CH_W'(CHANNELS) : servo_count_reg;
    assign ch_valid    = ({1'b0, ch_reg} < (CH_W+1)'(CHANNELS));
    assign slot_in_use = !slot_reg[SLOT_W-1] && (slot_reg < {1'b0, used});
    assign slot_inc    = slot_reg + SLOT_W'(1);
    assign expire_now  = running_reg && (countdown_reg <= CNT_W'(1));
    assign write_angle = ($signed(v_reg) < $signed({1'b0, min_pulse_reg}));

    always_comb
    begin
        for (int i = 0; i < CHANNELS; i++)
        begin
            ch_mask[i]   = (ch_reg == CH_W'(i));
            slot_mask[i] = (slot_reg == SLOT_W'(i));
        end
    end

    // Trimmed limits and spans of the addressed channel
    assign lo_s    = trim_limit(min_pulse_reg, cur_reg.low_trim);
    assign hi_s    = trim_limit(max_pulse_reg, cur_reg.high_trim);
    assign span    = SPAN_W'(hi_s) - SPAN_W'(lo_s);
    assign wr_prod = v_reg * span;
    assign rb_off  = $signed({{(SPAN_W-US_W){1'b0}}, cur_reg.width}) + SPAN_W'(1)
                     - SPAN_W'(lo_s);
    assign rb_prod = rb_off * ANGLE_SPAN;

    // Clamp to the trimmed range, lower test first, then to 0..4095
    assign lo_x = WV_W'(lo_s);
    assign hi_x = WV_W'(hi_s);
    always_comb
    begin
        if (wval_reg < lo_x)
            w_lim = lo_x;
        else if (wval_reg > hi_x)
            w_lim = hi_x;
        else
            w_lim = wval_reg;
        if (w_lim < 0)
            w_sat = '0;
        else if (w_lim > WV_W'(US_MAX))
            w_sat = US_MAX;
        else
            w_sat = w_lim[US_W-1:0];
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = (func_t'(s_tuser) == FN_TICK) ? ST_TICK : ST_CH_RD;
            end
            ST_TICK:     state_next = expire_now ? ST_LOAD : ST_CH_RD;
            ST_LOAD:     state_next = ST_CH_RD;
            ST_CH_RD:    state_next = ST_CH;
            ST_CH:
            begin
                if (!ch_valid)
                    state_next = ST_OUT;
                else if (func_reg == FN_WRITE)
                    state_next = write_angle ? ST_WR_MUL : ST_WR_CLAMP;
                else
                    state_next = ST_RB_MUL;
            end
            ST_WR_MUL:   state_next = ST_WR_DIV;
            ST_WR_DIV:   state_next = div_done ? ST_WR_CLAMP : ST_WR_DIV;
            ST_WR_CLAMP: state_next = ST_RB_MUL;
            ST_RB_MUL:   state_next = (span == '0) ? ST_OUT : ST_RB_DIV;
            ST_RB_DIV:   state_next = div_done ? ST_OUT : ST_RB_DIV;
            ST_OUT:      state_next = out_free ? ST_IDLE : ST_OUT;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath, RAM and output control
    always_comb
    begin
        servo_count_next = servo_count_reg;
        refresh_next     = refresh_reg;
        min_pulse_next   = min_pulse_reg;
        max_pulse_next   = max_pulse_reg;
        default_next     = default_reg;
        slot_next        = slot_reg;
        countdown_next   = countdown_reg;
        frame_sum_next   = frame_sum_reg;
        active_next      = active_reg;
        entry_vld_next   = entry_vld_reg;
        pins_next        = pins_reg;
        running_next     = running_reg;
        div_go_next      = 1'b0;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        func_next        = func_reg;
        ch_next          = ch_reg;
        v_next           = v_reg;
        min_us_next      = min_us_reg;
        max_us_next      = max_us_reg;
        cur_next         = cur_reg;
        rd_vld_next      = rd_vld_reg;
        mul_next         = mul_reg;
        den_next         = den_reg;
        wval_next        = wval_reg;
        res_angle_next   = res_angle_reg;
        res_status_next  = res_status_reg;
        out_pins_next    = out_pins_reg;
        out_width_next   = out_width_reg;
        out_angle_next   = out_angle_reg;
        out_status_next  = out_status_reg;
        ram_we           = 1'b0;
        ram_waddr        = ch_reg[CH_AW-1:0];
        ram_wdata        = cur_reg;
        ram_re           = 1'b0;
        ram_raddr        = ch_reg[CH_AW-1:0];

        // Take configuration writes
        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_SERVO_COUNT:   servo_count_next = cfg_wdata[CH_W-1:0];
                REG_REFRESH_TICKS: refresh_next     = cfg_wdata[CNT_W-1:0];
                REG_MIN_PULSE:     min_pulse_next   = cfg_wdata[US_W-1:0];
                REG_MAX_PULSE:     max_pulse_next   = cfg_wdata[US_W-1:0];
                REG_DEFAULT_PULSE: default_next     = cfg_wdata[US_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            // Latch the item
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next   = func_t'(s_tuser);
                    ch_next     = s_tdata[3:0];
                    v_next      = $signed(s_tdata[19:4]);
                    min_us_next = s_tdata[31:20];
                    max_us_next = s_tdata[43:32];
                end
            end
            // Count down, or close the slot and fetch the next width
            ST_TICK:
            begin
                if (expire_now)
                begin
                    if (slot_reg == SLOT_GAP)
                        frame_sum_next = '0;
                    else if (slot_in_use && |(active_reg & slot_mask))
                        pins_next = pins_reg & ~slot_mask;
                    slot_next = slot_inc;
                    ram_re    = (slot_inc < {1'b0, used});
                    ram_raddr = slot_inc[CH_AW-1:0];
                    rd_vld_next = entry_vld_reg[slot_inc[CH_AW-1:0]];
                end
                else if (running_reg)
                begin
                    countdown_next = countdown_reg - CNT_W'(1);
                end
            end
            // Load the next pulse, or the rest of the frame
            ST_LOAD:
            begin
                if (slot_in_use)
                begin
                    countdown_next = CNT_W'(ent.width);
                    frame_sum_next = frame_sum_reg + SUM_W'(ent.width);
                    if (|(active_reg & slot_mask))
                        pins_next = pins_reg | slot_mask;
                end
                else
                begin
                    if ((SUM_W+1)'(frame_sum_reg) + (SUM_W+1)'(OVERRUN_GAP)
                        < (SUM_W+1)'(refresh_reg))
                        countdown_next = refresh_reg - frame_sum_reg[CNT_W-1:0];
                    else
                        countdown_next = OVERRUN_GAP;
                    slot_next = SLOT_GAP;
                end
            end
            // Fetch the addressed channel
            ST_CH_RD:
            begin
                if (ch_valid)
                begin
                    ram_re      = 1'b1;
                    rd_vld_next = entry_vld_reg[ch_reg[CH_AW-1:0]];
                end
            end
            // Apply the channel operation
            ST_CH:
            begin
                cur_next = ent;
                if (!ch_valid)
                begin
                    res_angle_next  = '0;
                    res_status_next = STAT_INVALID;
                end
                else
                begin
                    unique case (func_reg)
                        FN_ATTACH:
                        begin
                            cur_next.width     = default_reg;
                            cur_next.low_trim  = sat_trim(min_pulse_reg, min_us_reg);
                            cur_next.high_trim = sat_trim(max_pulse_reg, max_us_reg);
                            ram_we             = 1'b1;
                            ram_wdata          = cur_next;
                            entry_vld_next     = entry_vld_reg | ch_mask;
                            if (active_reg == '0)
                            begin
                                countdown_next = refresh_reg;
                                running_next   = 1'b1;
                            end
                            active_next = active_reg | ch_mask;
                        end
                        FN_DETACH:
                        begin
                            active_next = active_reg & ~ch_mask;
                            if ((active_reg & ~ch_mask) == '0)
                                running_next = 1'b0;
                        end
                        FN_WRITE:
                        begin
                            wval_next = WV_W'(v_reg);
                        end
                        FN_TICK:
                        begin
                        end
                    endcase
                end
            end
            // Scale the angle by the trimmed span
            ST_WR_MUL:
            begin
                mul_next    = wr_prod[DIV_NUM_W-1:0];
                den_next    = DIV_DEN_W'(ANGLE_SPAN);
                div_go_next = 1'b1;
            end
            ST_WR_DIV:
            begin
                if (div_done)
                    wval_next = WV_W'(div_quo) + lo_x;
            end
            // Clamp and store the new width
            ST_WR_CLAMP:
            begin
                cur_next.width = w_sat;
                ram_we         = 1'b1;
                ram_wdata      = cur_next;
                entry_vld_next = entry_vld_reg | ch_mask;
            end
            // Form the read-back angle
            ST_RB_MUL:
            begin
                if (span == '0)
                begin
                    res_angle_next  = '0;
                    res_status_next = STAT_EMPTY;
                end
                else
                begin
                    mul_next    = DIV_NUM_W'(rb_prod);
                    den_next    = DIV_DEN_W'(span);
                    div_go_next = 1'b1;
                end
            end
            ST_RB_DIV:
            begin
                if (div_done)
                begin
                    res_status_next = STAT_OK;
                    if (div_quo < 0)
                        res_angle_next = '0;
                    else if (div_quo > DIV_NUM_W'(ANGLE_MAX))
                        res_angle_next = ANGLE_MAX;
                    else
                        res_angle_next = div_quo[ANG_W-1:0];
                end
            end
            // Hand the result to the output register
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tvalid_next   = 1'b1;
                    out_pins_next   = PIN_W'(pins_reg);
                    out_width_next  = ch_valid ? cur_reg.width : '0;
                    out_angle_next  = res_angle_reg;
                    out_status_next = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            servo_count_reg <= RST_SERVO_COUNT;
            refresh_reg     <= RST_REFRESH;
            min_pulse_reg   <= RST_MIN_PULSE;
            max_pulse_reg   <= RST_MAX_PULSE;
            default_reg     <= RST_DEFAULT;
            slot_reg        <= SLOT_GAP;
            countdown_reg   <= RST_REFRESH;
            frame_sum_reg   <= '0;
            active_reg      <= '0;
            entry_vld_reg   <= '0;
            pins_reg        <= '0;
            running_reg     <= 1'b0;
            div_go_reg      <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            servo_count_reg <= servo_count_next;
            refresh_reg     <= refresh_next;
            min_pulse_reg   <= min_pulse_next;
            max_pulse_reg   <= max_pulse_next;
            default_reg     <= default_next;
            slot_reg        <= slot_next;
            countdown_reg   <= countdown_next;
            frame_sum_reg   <= frame_sum_next;
            active_reg      <= active_next;
            entry_vld_reg   <= entry_vld_next;
            pins_reg        <= pins_next;
            running_reg     <= running_next;
            div_go_reg      <= div_go_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        ch_reg         <= ch_next;
        v_reg          <= v_next;
        min_us_reg     <= min_us_next;
        max_us_reg     <= max_us_next;
        cur_reg        <= cur_next;
        rd_vld_reg     <= rd_vld_next;
        mul_reg        <= mul_next;
        den_reg        <= den_next;
        wval_reg       <= wval_next;
        res_angle_reg  <= res_angle_next;
        res_status_reg <= res_status_next;
        out_pins_reg   <= out_pins_next;
        out_width_reg  <= out_width_next;
        out_angle_reg  <= out_angle_next;
        out_status_reg <= out_status_next;
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_angle_reg, out_width_reg, out_pins_reg};
    assign m_tuser  = out_status_reg;

endmodule

// ===== sv/sps_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; width and depth come from its parameters.
module sps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/sps_div.sv =====
// Signed iterative divider, quotient truncated toward zero, two bits per cycle.
// Depends on sps_pkg for its operand widths.
module sps_div
    import sps_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [DIV_NUM_W-1:0] num,
    input  logic signed [DIV_DEN_W-1:0] den,
    output logic                        done,
    output logic signed [DIV_NUM_W-1:0] quo
);

    localparam int STEPS = DIV_NUM_W / DIV_BITS;
    localparam int SC_W  = $clog2(STEPS + 1);

    logic                  busy_reg;
    logic [SC_W-1:0]       cnt_reg;
    logic                  done_reg;
    logic [DIV_NUM_W-1:0]  quo_reg;
    logic [DIV_DEN_W-1:0]  rem_reg;
    logic [DIV_DEN_W-1:0]  den_mag_reg;
    logic                  neg_reg;
    logic [DIV_NUM_W-1:0]  res_reg;

    logic [DIV_NUM_W-1:0]  num_mag;
    logic [DIV_DEN_W-1:0]  den_mag;
    logic [DIV_NUM_W-1:0]  quo_s;
    logic [DIV_DEN_W-1:0]  rem_s;
    logic [DIV_DEN_W:0]    trial;
    logic                  last_step;

    // Operand magnitudes
    assign num_mag   = num[DIV_NUM_W-1] ? (~num + DIV_NUM_W'(1)) : num;
    assign den_mag   = den[DIV_DEN_W-1] ? (~den + DIV_DEN_W'(1)) : den;
    assign last_step = busy_reg && (cnt_reg == SC_W'(1));

    // Restoring division steps for one cycle
    always_comb
    begin
        rem_s = rem_reg;
        quo_s = quo_reg;
        trial = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial = {rem_s, quo_s[DIV_NUM_W-1]};
            quo_s = {quo_s[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_mag_reg})
            begin
                rem_s    = DIV_DEN_W'(trial - {1'b0, den_mag_reg});
                quo_s[0] = 1'b1;
            end
            else
            begin
                rem_s = trial[DIV_DEN_W-1:0];
            end
        end
    end

    // Step counter and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= last_step;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= SC_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - SC_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Operand load, shift and sign fix
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= num_mag;
            rem_reg     <= '0;
            den_mag_reg <= den_mag;
            neg_reg     <= num[DIV_NUM_W-1] ^ den[DIV_DEN_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_s;
            rem_reg <= rem_s;
            if (last_step)
            begin
                res_reg <= neg_reg ? (~quo_s + DIV_NUM_W'(1)) : quo_s;
            end
        end
    end

    assign done = done_reg;
    assign quo  = $signed(res_reg);

endmodule

// ===== sv/sps_checker.sv =====
// Port-level checks on the result side of the servo pulse sequencer.
// Depends on sps_pkg and servo_pulse_sequencer_macros.svh; bound to the top level.
`include "servo_pulse_sequencer_macros.svh"

module sps_checker
    import sps_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [STAT_W-1:0]     m_tuser
);

    // A stalled item stays offered
    `SPS_ASSERT_NEXT(a_hold_valid, m_tvalid && !m_tready, m_tvalid, "result item dropped while stalled")

    // An invalid channel reports no width and no angle
    `SPS_ASSERT(a_invalid_zero, (m_tvalid && (m_tuser == STAT_INVALID)) |-> (m_tdata[31:12] == 20'd0), "invalid channel with nonzero readback")

    // An empty trim range reports no angle
    `SPS_ASSERT(a_empty_angle, (m_tvalid && (m_tuser == STAT_EMPTY)) |-> (m_tdata[31:24] == 8'd0), "empty trim range with nonzero angle")

    // Only defined status codes leave the block
    `SPS_ASSERT(a_status_code, m_tvalid |-> ((m_tuser == STAT_OK) || (m_tuser == STAT_INVALID) || (m_tuser == STAT_EMPTY)), "undefined status code")

endmodule

bind servo_pulse_sequencer sps_checker u_sps_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
